// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition in the same cycle implies consequence in the same cycle.
`define LFP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Condition in this cycle implies consequence in the next cycle.
`define LFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LFP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define LFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/lfp_pkg.sv
// ----------------------------------------------------------------------------
// lfp_pkg
// Widths, constants and register codes of the line follower steering block.
// ----------------------------------------------------------------------------
package lfp_pkg;

    localparam int POS_W      = 12;
    localparam int TIME_W     = 32;
    localparam int GAIN_W     = 18;
    localparam int TARGET_W   = 11;
    localparam int STEER_W    = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIME = 2'd0,
        CFG_GAIN_P     = 2'd1,
        CFG_GAIN_I     = 2'd2,
        CFG_GAIN_D     = 2'd3
    } cfg_index_t;

    localparam logic [GAIN_W-1:0] GAIN_P_RST = 18'd17920;
    localparam logic [GAIN_W-1:0] GAIN_I_RST = 18'd333;
    localparam logic [GAIN_W-1:0] GAIN_D_RST = 18'd124160;

    // PID constants in signed Q8.8; STEER_MAX is a whole steer value.
    localparam logic signed [15:0] ERR_CENTER = 16'sd1152;
    localparam logic signed [15:0] SEP_LIMIT  = 16'sd896;
    localparam logic signed [16:0] INT_LIMIT  = 17'sd7680;
    localparam logic signed [15:0] SOFT_BAND  = 16'sd256;
    localparam logic signed [21:0] STEER_MAX  = 22'sd400;

    // Speed profile times in ms.
    localparam logic [TIME_W-1:0] RAMP_END   = 32'd2000;
    localparam logic [TIME_W-1:0] SLOW_BEGIN = 32'd15000;
    localparam logic [TIME_W-1:0] SLOW_END   = 32'd16000;
    localparam logic [TIME_W-1:0] STOP_BEGIN = 32'd18000;
    localparam logic [TIME_W-1:0] STOP_END   = 32'd18500;
    localparam logic [TIME_W-1:0] BRAKE_LEN  = 32'd150;

    // Profile speeds in units of 1/40.
    localparam logic [14:0] P40_FLOOR  = 15'd6000;
    localparam logic [14:0] P40_CRUISE = 15'd16000;
    localparam logic [14:0] P40_CRAWL  = 15'd4000;

    // Base speed is in units of 1/6000; division by 6000 uses a reciprocal.
    localparam logic [21:0] BASE_DEN    = 22'd6000;
    localparam logic [23:0] BASE_RECIP  = 24'd11453246;
    localparam int          RECIP_SHIFT = 36;

endpackage

// File: hdl/lfp_if.sv
// ----------------------------------------------------------------------------
// lfp_sample_if, lfp_result_if
// Valid/ready channels for input samples and steering results.
// ----------------------------------------------------------------------------
interface lfp_sample_if;
    logic                       valid;
    logic                       ready;
    logic [lfp_pkg::POS_W-1:0]  line_position;
    logic [lfp_pkg::TIME_W-1:0] now_ms;
    logic                       marker_seen;

    modport source (output valid, output line_position, output now_ms,
                    output marker_seen, input ready);
    modport sink   (input valid, input line_position, input now_ms,
                    input marker_seen, output ready);
endinterface

interface lfp_result_if;
    logic                                valid;
    logic                                ready;
    logic signed [lfp_pkg::TARGET_W-1:0] left_target;
    logic signed [lfp_pkg::TARGET_W-1:0] right_target;
    logic signed [lfp_pkg::STEER_W-1:0]  steer;
    logic                                is_braking;
    logic                                is_stopped;

    modport source (output valid, output left_target, output right_target,
                    output steer, output is_braking, output is_stopped,
                    input ready);
    modport sink   (input valid, input left_target, input right_target,
                    input steer, input is_braking, input is_stopped,
                    output ready);
endinterface

// File: hdl/line_follow_pid_speed_profile.sv
// ----------------------------------------------------------------------------
// line_follow_pid_speed_profile
// Steering PID with integral separation and a timed, brakeable base speed.
// ----------------------------------------------------------------------------
// A sample word is accepted in ST_IDLE and passes ST_PREP, ST_MUL_P to ST_CHECK,
// ST_FIX and ST_FINISH; the next is accepted only after the result word is loaded. The
// single 25x25 multiplier is shared by the three PID products, the base speed product
// and the two products of the divide by 6000, one per cycle.
// Reset (rst_n low, asynchronous) clears the PID and brake state and loads
// the register defaults; the block is ready in the first cycle after reset.
`include "assert_macros.svh"

module line_follow_pid_speed_profile (
    input  logic                                clk,
    input  logic                                rst_n,
    lfp_sample_if.sink                          sample,
    lfp_result_if.source                        result,
    input  logic                                cfg_write,
    input  logic [lfp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lfp_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_MUL_B,
        ST_QUOT,
        ST_CHECK,
        ST_FIX,
        ST_FINISH
    } state_t;

    localparam int TGT_CALC_W = lfp_pkg::TARGET_W + 1;

    state_t state_reg;

    // Configuration.
    logic [lfp_pkg::TIME_W-1:0] start_time_reg;
    logic [lfp_pkg::GAIN_W-1:0] gain_p_reg;
    logic [lfp_pkg::GAIN_W-1:0] gain_i_reg;
    logic [lfp_pkg::GAIN_W-1:0] gain_d_reg;

    // Controller state.
    logic signed [15:0]         prev_error_reg;
    logic signed [15:0]         error_integral_reg;
    logic                       brake_active_reg;
    logic                       stopped_latch_reg;
    logic [lfp_pkg::TIME_W-1:0] brake_begin_reg;

    // Captured sample word.
    logic [lfp_pkg::POS_W-1:0]  pos_reg;
    logic [lfp_pkg::TIME_W-1:0] now_reg;
    logic                       marker_reg;

    // Datapath.
    logic signed [15:0] dif_reg;
    logic [19:0]        gd_eff_reg;
    logic [14:0]        p40_reg;
    logic [7:0]         k_reg;
    logic signed [49:0] prod_reg;
    logic signed [39:0] acc_reg;
    logic [21:0]        base_reg;
    logic signed [9:0]  turn_reg;
    logic [8:0]         q_reg;
    logic [8:0]         b_reg;
    logic               rnz_reg;

    // Next values: error, brake and profile terms are taken in ST_PREP, the rest later.
    logic signed [15:0]         err_next;
    logic signed [15:0]         integral_next;
    logic signed [15:0]         dif_next;
    logic [19:0]                gd_eff_next;
    logic                       brake_active_next;
    logic                       stopped_latch_next;
    logic [lfp_pkg::TIME_W-1:0] brake_begin_next;
    logic [14:0]                p40_next;
    logic [7:0]                 k_next;
    logic signed [9:0]          turn_next;
    logic [8:0]                 b_next;
    logic                       rnz_next;
    logic signed [TGT_CALC_W-1:0] left_next;
    logic signed [TGT_CALC_W-1:0] right_next;

    logic signed [24:0] mul_a;
    logic signed [24:0] mul_b;

    logic sample_fire;
    logic finish_go;

    assign sample.ready = (state_reg == ST_IDLE);
    assign sample_fire  = sample.valid && sample.ready;
    assign finish_go    = (state_reg == ST_FINISH) && (!result.valid || result.ready);

    // Base speed profile in units of 1/40. The brake variant has a gentler
    // start ramp that begins at the floor.
    function automatic logic [14:0] profile40(input logic [31:0] e, input logic brk);
        logic [10:0] e_lo;
        logic [13:0] e8;
        logic [9:0]  d_slow;
        logic [14:0] t_stop;
        logic [14:0] res;
        e_lo   = e[10:0];
        e8     = {e_lo, 3'b000};
        d_slow = 10'(e[13:0] - 14'(lfp_pkg::SLOW_BEGIN));
        t_stop = e[14:0] - 15'(lfp_pkg::STOP_BEGIN);
        if (e < lfp_pkg::RAMP_END) begin
            if (brk) begin
                res = lfp_pkg::P40_FLOOR + {2'b00, e_lo, 2'b00} + {4'b0000, e_lo};
            end else if ({1'b0, e8} < lfp_pkg::P40_FLOOR) begin
                res = lfp_pkg::P40_FLOOR;
            end else begin
                res = {1'b0, e8};
            end
        end else if (e < lfp_pkg::SLOW_BEGIN) begin
            res = lfp_pkg::P40_CRUISE;
        end else if (e < lfp_pkg::SLOW_END) begin
            res = lfp_pkg::P40_CRUISE - {2'b00, d_slow, 3'b000} - {3'b000, d_slow, 2'b00};
        end else if (e < lfp_pkg::STOP_BEGIN) begin
            res = lfp_pkg::P40_CRAWL;
        end else if (e < lfp_pkg::STOP_END) begin
            res = lfp_pkg::P40_CRAWL - {t_stop[11:0], 3'b000};
        end else begin
            res = '0;
        end
        return res;
    endfunction

    // Error terms, brake decision and profile operands.
    always_comb
    begin
        logic signed [16:0] int_sum;
        logic               separate;
        logic               start_brake;
        logic [31:0]        elapsed;
        logic [31:0]        brake_time;

        err_next = lfp_pkg::ERR_CENTER - $signed({4'b0000, pos_reg});
        separate = (err_next > lfp_pkg::SEP_LIMIT) || (err_next < -lfp_pkg::SEP_LIMIT);
        int_sum  = separate ? 17'sd0
                            : ({error_integral_reg[15], error_integral_reg}
                               + {err_next[15], err_next});
        if (int_sum >= lfp_pkg::INT_LIMIT) begin
            integral_next = 16'(lfp_pkg::INT_LIMIT);
        end else if (int_sum <= -lfp_pkg::INT_LIMIT) begin
            integral_next = 16'(-lfp_pkg::INT_LIMIT);
        end else begin
            integral_next = int_sum[15:0];
        end
        dif_next = err_next - prev_error_reg;

        // Inside the soft band the derivative gain is scaled by 3/4.
        if ((err_next > -lfp_pkg::SOFT_BAND) && (err_next < lfp_pkg::SOFT_BAND)) begin
            gd_eff_next = {1'b0, gain_d_reg, 1'b0} + {2'b00, gain_d_reg};
        end else begin
            gd_eff_next = {gain_d_reg, 2'b00};
        end

        start_brake       = marker_reg && !brake_active_reg && !stopped_latch_reg;
        brake_active_next = brake_active_reg || start_brake;
        brake_begin_next  = start_brake ? now_reg : brake_begin_reg;
        elapsed           = now_reg - start_time_reg;
        brake_time        = now_reg - brake_begin_next;

        stopped_latch_next = stopped_latch_reg;
        p40_next           = '0;
        k_next             = '0;
        priority if (stopped_latch_reg) begin
            stopped_latch_next = 1'b1;
        end else if (brake_active_next) begin
            if (brake_time >= lfp_pkg::BRAKE_LEN) begin
                stopped_latch_next = 1'b1;
            end else begin
                p40_next = profile40(elapsed, 1'b1);
                k_next   = 8'(lfp_pkg::BRAKE_LEN) - brake_time[7:0];
            end
        end else if (elapsed >= lfp_pkg::STOP_END) begin
            stopped_latch_next = 1'b1;
        end else begin
            p40_next = profile40(elapsed, 1'b0);
            k_next   = 8'(lfp_pkg::BRAKE_LEN);
        end
    end

    // Steer: PID sum in units of 2^-18 truncated toward zero, then clamped.
    always_comb
    begin
        logic signed [39:0] acc_adj;
        logic signed [21:0] turn_wide;
        acc_adj   = acc_reg + (acc_reg[39] ? 40'sh3FFFF : 40'sh0);
        turn_wide = acc_adj[39:18];
        if (turn_wide > lfp_pkg::STEER_MAX) begin
            turn_next = 10'(lfp_pkg::STEER_MAX);
        end else if (turn_wide < -lfp_pkg::STEER_MAX) begin
            turn_next = 10'(-lfp_pkg::STEER_MAX);
        end else begin
            turn_next = turn_wide[9:0];
        end
    end

    // Reciprocal estimate is exact or one low; one compare fixes it. A
    // remainder of exactly 6000 means the estimate was low and divides evenly.
    always_comb
    begin
        logic [21:0] rem;
        rem      = base_reg - prod_reg[21:0];
        b_next   = (rem >= lfp_pkg::BASE_DEN) ? (q_reg + 9'd1) : q_reg;
        rnz_next = (rem != '0) && (rem != lfp_pkg::BASE_DEN);
    end

    // Wheel targets: floor(base) -/+ turn, one up where the exact value is
    // negative and not whole, which truncates toward zero.
    always_comb
    begin
        logic signed [TGT_CALC_W-1:0] b_ext;
        logic signed [TGT_CALC_W-1:0] t_ext;
        logic signed [TGT_CALC_W-1:0] dl;
        logic signed [TGT_CALC_W-1:0] dr;
        b_ext = $signed({{(TGT_CALC_W-9){1'b0}}, b_reg});
        t_ext = $signed({{(TGT_CALC_W-10){turn_reg[9]}}, turn_reg});
        dl    = b_ext - t_ext;
        dr    = b_ext + t_ext;
        left_next  = dl + $signed({{(TGT_CALC_W-1){1'b0}}, dl[TGT_CALC_W-1] && rnz_reg});
        right_next = dr + $signed({{(TGT_CALC_W-1){1'b0}}, dr[TGT_CALC_W-1] && rnz_reg});
    end

    // Operand select for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_P:
            begin
                mul_a = $signed({7'b0, gain_p_reg});
                mul_b = $signed({{9{prev_error_reg[15]}}, prev_error_reg});
            end
            ST_MUL_I:
            begin
                mul_a = $signed({7'b0, gain_i_reg});
                mul_b = $signed({{9{error_integral_reg[15]}}, error_integral_reg});
            end
            ST_MUL_D:
            begin
                mul_a = $signed({5'b0, gd_eff_reg});
                mul_b = $signed({{9{dif_reg[15]}}, dif_reg});
            end
            ST_MUL_B:
            begin
                mul_a = $signed({10'b0, p40_reg});
                mul_b = $signed({17'b0, k_reg});
            end
            ST_QUOT:
            begin
                mul_a = $signed({3'b0, prod_reg[21:0]});
                mul_b = $signed({1'b0, lfp_pkg::BASE_RECIP});
            end
            ST_CHECK:
            begin
                mul_a = $signed({16'b0, prod_reg[lfp_pkg::RECIP_SHIFT +: 9]});
                mul_b = $signed({3'b0, lfp_pkg::BASE_DEN});
            end
            ST_IDLE, ST_PREP, ST_FIX, ST_FINISH:
            begin
                mul_a = '0;
                mul_b = '0;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Sequencer, configuration, controller state and the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg          <= ST_IDLE;
            result.valid       <= 1'b0;
            start_time_reg     <= '0;
            gain_p_reg         <= lfp_pkg::GAIN_P_RST;
            gain_i_reg         <= lfp_pkg::GAIN_I_RST;
            gain_d_reg         <= lfp_pkg::GAIN_D_RST;
            prev_error_reg     <= '0;
            error_integral_reg <= '0;
            brake_active_reg   <= 1'b0;
            stopped_latch_reg  <= 1'b0;
            brake_begin_reg    <= '0;
        end else begin
            if (cfg_write) begin
                unique case (lfp_pkg::cfg_index_t'(cfg_index))
                    lfp_pkg::CFG_START_TIME: start_time_reg <= cfg_data;
                    lfp_pkg::CFG_GAIN_P:     gain_p_reg <= cfg_data[lfp_pkg::GAIN_W-1:0];
                    lfp_pkg::CFG_GAIN_I:     gain_i_reg <= cfg_data[lfp_pkg::GAIN_W-1:0];
                    lfp_pkg::CFG_GAIN_D:     gain_d_reg <= cfg_data[lfp_pkg::GAIN_W-1:0];
                endcase
            end

            if (result.valid && result.ready && !finish_go) begin
                result.valid <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sample_fire) begin
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    prev_error_reg     <= err_next;
                    error_integral_reg <= integral_next;
                    brake_active_reg   <= brake_active_next;
                    stopped_latch_reg  <= stopped_latch_next;
                    brake_begin_reg    <= brake_begin_next;
                    state_reg          <= ST_MUL_P;
                end
                ST_MUL_P: state_reg <= ST_MUL_I;
                ST_MUL_I: state_reg <= ST_MUL_D;
                ST_MUL_D: state_reg <= ST_MUL_B;
                ST_MUL_B: state_reg <= ST_QUOT;
                ST_QUOT:  state_reg <= ST_CHECK;
                ST_CHECK: state_reg <= ST_FIX;
                ST_FIX:   state_reg <= ST_FINISH;
                ST_FINISH:
                begin
                    if (finish_go) begin
                        result.valid        <= 1'b1;
                        result.left_target  <= left_next[lfp_pkg::TARGET_W-1:0];
                        result.right_target <= right_next[lfp_pkg::TARGET_W-1:0];
                        result.steer        <= turn_reg;
                        result.is_braking   <= brake_active_reg && !stopped_latch_reg;
                        result.is_stopped   <= stopped_latch_reg;
                        state_reg           <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (sample_fire) begin
            pos_reg    <= sample.line_position;
            now_reg    <= sample.now_ms;
            marker_reg <= sample.marker_seen;
        end
        if (state_reg == ST_PREP) begin
            dif_reg    <= dif_next;
            gd_eff_reg <= gd_eff_next;
            p40_reg    <= p40_next;
            k_reg      <= k_next;
        end
        if (state_reg == ST_MUL_I) begin
            acc_reg <= $signed({prod_reg[37:0], 2'b00});
        end
        if (state_reg == ST_MUL_D) begin
            acc_reg <= acc_reg + $signed({prod_reg[37:0], 2'b00});
        end
        if (state_reg == ST_MUL_B) begin
            acc_reg <= acc_reg + $signed(prod_reg[39:0]);
        end
        if (state_reg == ST_QUOT) begin
            base_reg <= prod_reg[21:0];
            turn_reg <= turn_next;
        end
        if (state_reg == ST_CHECK) begin
            q_reg <= prod_reg[lfp_pkg::RECIP_SHIFT +: 9];
        end
        if (state_reg == ST_FIX) begin
            b_reg   <= b_next;
            rnz_reg <= rnz_next;
        end
    end

    `LFP_ASSERT_NEXT(a_stop_sticky, clk, rst_n, stopped_latch_reg, stopped_latch_reg, "stop latch cleared")
    `LFP_ASSERT_IMPLY(a_steer_range, clk, rst_n, result.valid, (result.steer <= 10'sd400) && (result.steer >= -10'sd400), "steer out of range")
    `LFP_ASSERT_IMPLY(a_brake_stop_excl, clk, rst_n, result.valid, !(result.is_braking && result.is_stopped), "braking while stopped")
    `LFP_ASSERT_IMPLY(a_integral_range, clk, rst_n, 1'b1, (error_integral_reg <= 16'sd7680) && (error_integral_reg >= -16'sd7680), "integral beyond clamp")
    `LFP_ASSERT_NEXT(a_finish_loads, clk, rst_n, finish_go, result.valid && (state_reg == ST_IDLE), "result word not loaded")

endmodule
